// File: rtl/core/feedback_delay_line_macros.svh
// Assertion helpers used by the core RTL (feedback_delay_line).
`ifndef FEEDBACK_DELAY_LINE_MACROS_SVH
`define FEEDBACK_DELAY_LINE_MACROS_SVH

// Same-cycle implication.
`define FDL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fdl assertion failed");

// Next-cycle implication.
`define FDL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fdl assertion failed");

`endif

// File: rtl/core/fdl_pkg.sv
`timescale 1ns / 1ps
package fdl_pkg;

	localparam int DELAY_DEPTH  = 65536;
	localparam int SAMPLE_WIDTH = 24;
	localparam int ADDR_W       = $clog2(DELAY_DEPTH);

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int WHOLE_W    = 16;
	localparam int FRAC_W     = 8;
	localparam int Q15_SHIFT  = 15;
	localparam int Q15_W      = 17;           // clamped unsigned Q2.15, up to one
	localparam int Q15_ONE    = 32768;
	localparam int Q15_HALF   = 16384;
	localparam int FRAC_HALF  = 128;
	localparam int GAIN_RESET = 6554;

	localparam int DIFF_W = SAMPLE_WIDTH + 1;
	localparam int SAT_W  = SAMPLE_WIDTH + 2;
	localparam int FB_W   = SAMPLE_WIDTH + Q15_W + 1;
	localparam int IP_W   = DIFF_W + FRAC_W + 1;
	localparam int MIX_W  = DIFF_W + Q15_W + 1;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t CFG_DELAY_WHOLE    = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_DELAY_FRACTION = cfg_idx_t'(1);
	localparam cfg_idx_t CFG_FEEDBACK_GAIN  = cfg_idx_t'(2);
	localparam cfg_idx_t CFG_WET_MIX        = cfg_idx_t'(3);

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic    we;
		addr_t   waddr;
		sample_t wdata;
		addr_t   raddr;
	} store_req_t;

	function automatic sample_t sat_sample(input logic signed [SAT_W-1:0] v);
		sample_t r;
		if (v > SAT_W'(SAMPLE_MAX)) begin
			r = SAMPLE_MAX;
		end else if (v < SAT_W'(SAMPLE_MIN)) begin
			r = SAMPLE_MIN;
		end else begin
			r = sample_t'(v);
		end
		return r;
	endfunction

endpackage

// File: rtl/core/fdl_store.sv
`timescale 1ns / 1ps
module fdl_store (
	input  logic               clk,
	input  logic               arst_n,
	input  fdl_pkg::store_req_t req,
	output fdl_pkg::sample_t    rdata,
	output logic               busy
);
	import fdl_pkg::*;

	sample_t mem [DELAY_DEPTH];
	sample_t rdata_q;
	addr_t   clr_q;
	logic    busy_q;

	logic    we;
	addr_t   waddr;
	sample_t wdata;

	// zero sweep after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		we    = busy_q | req.we;
		waddr = busy_q ? clr_q : req.waddr;
		wdata = busy_q ? '0 : req.wdata;
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[req.raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

// File: rtl/core/feedback_delay_line.sv
// Flow: an accepted input beat steps through ST_OLD, ST_INTERP, ST_MIX and ST_FIN.
// A new sample is accepted only back in ST_IDLE: tap and older neighbor are read in
// consecutive states, then come the interpolation, mix and output load stages. While the output
// register holds a stalled beat, the next result waits in the final state.
// Reset: state, valid, write pointer and config registers take their reset values; the delay
// memory is then zeroed one entry per cycle (all 65536 entries) with in_stall high. Config is accepted meanwhile.
`timescale 1ns / 1ps
`include "feedback_delay_line_macros.svh"
module feedback_delay_line (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fdl_pkg::sample_t    sample_in,
	output logic                out_valid,
	input  logic                out_stall,
	output fdl_pkg::sample_t    sample_out,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  fdl_pkg::cfg_idx_t   cfg_index,
	input  fdl_pkg::cfg_data_t  cfg_data
);
	import fdl_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_OLD    = 5'b00010,
		ST_INTERP = 5'b00100,
		ST_MIX    = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;

	state_t state_q;

	logic [WHOLE_W-1:0] whole_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [Q15_W-1:0]   gain_q;
	logic [Q15_W-1:0]   mix_q;

	addr_t   wp_q;
	addr_t   tap_addr_q;
	sample_t dry_q;
	sample_t tap_q;
	logic signed [FB_W-1:0]  fb_prod_q;
	logic signed [IP_W-1:0]  ip_prod_q;
	logic signed [MIX_W-1:0] mix_prod_q;
	logic    out_valid_q;
	sample_t sample_out_q;

	store_req_t req;
	sample_t    rdata;
	logic       clr_busy;

	logic in_acc;
	logic out_load;
	logic signed [Q15_W:0]   gain_s;
	logic signed [Q15_W:0]   mix_s;
	logic signed [FRAC_W:0]  frac_s;
	logic signed [DIFF_W-1:0] diff;
	logic signed [FB_W-1:0]  fb_rnd;
	logic signed [FB_W-1:0]  fb_shift;
	logic signed [SAT_W-1:0] store_sum;
	logic signed [IP_W-1:0]  ip_rnd;
	logic signed [IP_W-1:0]  ip_shift;
	logic signed [DIFF_W-1:0] wet_wide;
	sample_t                 wet;
	logic signed [DIFF_W-1:0] wet_diff;
	logic signed [MIX_W-1:0] mix_rnd;
	logic signed [MIX_W-1:0] mix_shift;
	logic signed [SAT_W-1:0] out_sum;

	fdl_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata),
		.busy   (clr_busy)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_q <= '0;
			frac_q  <= '0;
			gain_q  <= Q15_W'(GAIN_RESET);
			mix_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DELAY_WHOLE: begin
					whole_q <= WHOLE_W'(cfg_data);
				end
				CFG_DELAY_FRACTION: begin
					frac_q <= cfg_data[FRAC_W-1:0];
				end
				CFG_FEEDBACK_GAIN: begin
					gain_q <= (cfg_data > CFG_DATA_W'(Q15_ONE)) ? Q15_W'(Q15_ONE)
						: Q15_W'(cfg_data);
				end
				CFG_WET_MIX: begin
					mix_q <= (cfg_data > CFG_DATA_W'(Q15_ONE)) ? Q15_W'(Q15_ONE)
						: Q15_W'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE) || clr_busy;
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	assign gain_s = $signed({1'b0, gain_q});
	assign mix_s  = $signed({1'b0, mix_q});
	assign frac_s = $signed({1'b0, frac_q});

	// feedback path: tap arrives from memory in ST_OLD
	always_comb begin
		fb_rnd    = fb_prod_q + $signed(FB_W'(Q15_HALF));
		fb_shift  = fb_rnd >>> Q15_SHIFT;
		store_sum = SAT_W'(dry_q) + SAT_W'(fb_shift);
	end

	// older neighbor arrives in ST_INTERP; tap*(256-f)+older*f = 256*tap + (older-tap)*f
	assign diff = DIFF_W'(rdata) - DIFF_W'(tap_q);

	always_comb begin
		ip_rnd   = ip_prod_q + $signed(IP_W'(FRAC_HALF));
		ip_shift = ip_rnd >>> FRAC_W;
		wet_wide = DIFF_W'(tap_q) + DIFF_W'(ip_shift);
		wet      = sample_t'(wet_wide);
		wet_diff = DIFF_W'(wet) - DIFF_W'(dry_q);
	end

	always_comb begin
		mix_rnd   = mix_prod_q + $signed(MIX_W'(Q15_HALF));
		mix_shift = mix_rnd >>> Q15_SHIFT;
		out_sum   = SAT_W'(dry_q) + SAT_W'(mix_shift);
	end

	always_comb begin
		req.we    = (state_q == ST_INTERP);
		req.waddr = wp_q;
		req.wdata = sat_sample(store_sum);
		req.raddr = (state_q == ST_IDLE) ? (wp_q - ADDR_W'(whole_q)) : (tap_addr_q - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_OLD;
					end
				end
				ST_OLD: begin
					state_q <= ST_INTERP;
				end
				ST_INTERP: begin
					wp_q    <= wp_q + 1'b1;
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dry_q      <= sample_in;
			tap_addr_q <= req.raddr;
		end
		if (state_q == ST_OLD) begin
			tap_q     <= rdata;
			fb_prod_q <= rdata * gain_s;
		end
		if (state_q == ST_INTERP) begin
			ip_prod_q <= diff * frac_s;
		end
		if (state_q == ST_MIX) begin
			mix_prod_q <= wet_diff * mix_s;
		end
		if (out_load) begin
			sample_out_q <= sat_sample(out_sum);
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	`FDL_ASSERT_NOW(a_no_accept_in_clear, clk, arst_n, clr_busy, in_stall)
	`FDL_ASSERT_NEXT(a_fin_holds, clk, arst_n, (state_q == ST_FIN) && !out_load, state_q == ST_FIN)
	`FDL_ASSERT_NEXT(a_wp_advance, clk, arst_n, state_q == ST_INTERP, wp_q == $past(wp_q) + 1'b1)

endmodule
